@@ rtl/core/bepe_pkg.sv @@
// Shared types, widths and register codes of the binary edge pixel extractor.
`default_nettype none

package bepe_pkg;

  // Raster and coordinate widths.
  localparam int MAX_WIDTH_DEFAULT = 256;
  localparam int CFG_WIDTH_W       = 9;
  localparam int CFG_HEIGHT_W      = 12;
  localparam int COORD_W           = 16;
  localparam int ROW_W             = 13;

  // Configuration port.
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_RASTER_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RASTER_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_X      = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_Y      = 2'd3;

  localparam logic [CFG_WIDTH_W-1:0]  RASTER_WIDTH_RESET  = 9'd8;
  localparam logic [CFG_HEIGHT_W-1:0] RASTER_HEIGHT_RESET = 12'd1;

  // Stream widths.
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 2 * COORD_W;

  // Line store entry: the pixel one row up and the pixel two rows up.
  localparam int ENTRY_W     = 2;
  localparam int ENTRY_ABOVE = 1;
  localparam int ENTRY_TWO   = 0;

  typedef struct packed {
    logic               is_edge;
    logic [COORD_W-1:0] edge_x;
    logic [COORD_W-1:0] edge_y;
    logic               glyph_done;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/binary_edge_pixel_extractor.sv @@
// Top level of the binary edge pixel extractor: scan counters, line store and edge decision.
`default_nettype none

// Usage
// The slave stream takes one raster pixel per transfer (s_tdata bit 0), row by
// row: raster_width times raster_height pixels, then one flush row whose pixel
// values are ignored. The transfer of a pixel in row r (r of 1 or more) decides
// pixel (x, r-1) of the row above and yields one result transfer on the master
// stream; pixels of row 0 yield nothing. A result carries the edge flag in
// m_tuser, the column and row plus the configured offsets in m_tdata, and
// m_tlast on the last flush-row pixel of the glyph.
// Throughput is one pixel per cycle while results are taken and no reload
// runs; a result is presented in the cycle after its pixel transfer. Both
// rows of the line store sit in one RAM with 2-bit entries, read two columns
// ahead through its single read port. When the receiver stalls, the result
// stays in the output register and s_tready drops until it is taken; in a
// cycle where the result is taken, a new pixel can be taken as well. Reset
// returns the counters and the control, configuration and output valid
// registers to reset; no clearing pass runs. A configuration write starts
// a reload of the window from the RAM (left, center, right) with s_tready low.
module binary_edge_pixel_extractor #(
  parameter int MAX_WIDTH = bepe_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Pixel stream. s_tdata: [0] pixel, [7:1] zero.
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [bepe_pkg::IN_DATA_W-1:0]    s_tdata,
  // Result stream. m_tdata: [15:0] edge_x, [31:16] edge_y. m_tuser: [0] is_edge.
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [bepe_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                                   m_tuser,
  output logic                                   m_tlast,
  // Configuration write port.
  input  wire logic                              cfg_we,
  input  wire logic [bepe_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bepe_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bepe_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = AW + 1;

  // Window reload sequence after a configuration write.
  localparam logic [1:0] FILL_IDLE   = 2'd0;
  localparam logic [1:0] FILL_LEFT   = 2'd1;
  localparam logic [1:0] FILL_CENTER = 2'd2;
  localparam logic [1:0] FILL_RIGHT  = 2'd3;

  logic [WW-1:0]           width_eff;
  logic [CFG_HEIGHT_W-1:0] height_eff;
  logic [COORD_W-1:0]      off_x;
  logic [COORD_W-1:0]      off_y;

  // Scan position and window state.
  logic [AW-1:0]      col;
  logic [ROW_W-1:0]   row;
  logic [1:0]         fill_state;
  logic               fwd;
  logic [ENTRY_W-1:0] fwd_data;
  logic [ENTRY_W-1:0] e0;
  logic               left_px;

  // Combinational decode of the current pixel.
  logic               accept;
  logic               busy;
  logic [AW-1:0]      x;
  logic [ROW_W-1:0]   r;
  logic [ROW_W-1:0]   h_ext;
  logic               flush;
  logic [WW-1:0]      x_inc;
  logic               last_col;
  logic               has_left;
  logic               has_right;
  logic               has_down;
  logic               pix;
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] e1;
  logic [ENTRY_W-1:0] wdata;
  logic [WW:0]        x_plus2;
  logic [WW:0]        x_plus2_wrap;
  logic [AW-1:0]      ahead_addr;
  logic [AW-1:0]      left_addr;
  logic [AW-1:0]      right_addr;
  logic [AW-1:0]      raddr;
  logic               re;
  logic               up;
  logic               center;
  logic               down;
  logic               left;
  logic               right;
  result_t            res;

  bepe_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .width_eff  (width_eff),
    .height_eff (height_eff),
    .off_x      (off_x),
    .off_y      (off_y)
  );

  assign busy     = (fill_state != FILL_IDLE);
  assign s_tready = !busy && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  // A stored column or row beyond the current raster size is pulled back in.
  always_comb begin
    if (WW'(col) >= width_eff) begin
      x = AW'(width_eff - WW'(1));
    end else begin
      x = col;
    end
    h_ext = ROW_W'(height_eff);
    r     = (row > h_ext) ? h_ext : row;
  end

  assign flush     = (r >= h_ext);
  assign x_inc     = WW'(x) + WW'(1);
  assign last_col  = (x_inc >= width_eff);
  assign has_left  = (x != '0);
  assign has_right = !last_col;
  assign has_down  = (r >= ROW_W'(2));
  assign pix       = s_tdata[0] && !flush;

  // The entry one column ahead comes from the RAM, or from the write of the
  // previous pixel when the raster is so narrow that both hit the same column.
  assign e1    = fwd ? fwd_data : rdata;
  assign wdata = {pix, e0[ENTRY_ABOVE]};

  // Read address two columns ahead, wrapping into the next row.
  always_comb begin
    x_plus2      = (WW+1)'(x) + (WW+1)'(2);
    x_plus2_wrap = x_plus2 - (WW+1)'(width_eff);
    if (width_eff == WW'(1)) begin
      ahead_addr = '0;
    end else if (x_plus2 >= (WW+1)'(width_eff)) begin
      ahead_addr = AW'(x_plus2_wrap);
    end else begin
      ahead_addr = AW'(x_plus2);
    end
  end

  assign left_addr  = has_left ? (x - AW'(1)) : x;
  assign right_addr = last_col ? '0 : AW'(x_inc);

  always_comb begin
    case (fill_state)
      FILL_LEFT:   raddr = left_addr;
      FILL_CENTER: raddr = x;
      FILL_RIGHT:  raddr = right_addr;
      default:     raddr = ahead_addr;
    endcase
  end

  assign re = accept || busy;

  bepe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept),
    .waddr (x),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Four-neighbor test on pixel (x, r-1). Neighbors outside the raster are clear.
  assign center = e0[ENTRY_ABOVE];
  assign up     = pix;
  assign down   = has_down && e0[ENTRY_TWO];
  assign left   = has_left && left_px;
  assign right  = has_right && e1[ENTRY_ABOVE];

  always_comb begin
    res.is_edge    = center && !(center && up && down && left && right);
    res.edge_x     = COORD_W'(x) + off_x;
    res.edge_y     = COORD_W'(r - ROW_W'(1)) + off_y;
    res.glyph_done = flush && last_col;
  end

  // Counters, reload sequence and forwarding flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      col        <= '0;
      row        <= '0;
      fill_state <= FILL_IDLE;
      fwd        <= 1'b0;
    end else begin
      if (cfg_we) begin
        fill_state <= FILL_LEFT;
      end else begin
        case (fill_state)
          FILL_LEFT:   fill_state <= FILL_CENTER;
          FILL_CENTER: fill_state <= FILL_RIGHT;
          FILL_RIGHT:  fill_state <= FILL_IDLE;
          default:     fill_state <= FILL_IDLE;
        endcase
      end
      if (fill_state == FILL_RIGHT) begin
        fwd <= 1'b0;
      end
      if (accept) begin
        fwd <= (ahead_addr == x);
        if (last_col) begin
          col <= '0;
          row <= flush ? '0 : (r + ROW_W'(1));
        end else begin
          col <= AW'(x_inc);
          row <= r;
        end
      end
    end
  end

  // Neighbor window.
  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_data <= wdata;
      e0       <= (width_eff == WW'(1)) ? wdata : e1;
      left_px  <= e0[ENTRY_ABOVE];
    end else if (fill_state == FILL_CENTER) begin
      left_px  <= rdata[ENTRY_TWO];
    end else if (fill_state == FILL_RIGHT) begin
      e0       <= rdata;
    end
  end

  bepe_out u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && (r != '0)),
    .res      (res),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/core/bepe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module bepe_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/bepe_cfg.sv @@
// Configuration registers and the clamped raster size derived from them.
`default_nettype none

module bepe_cfg #(
  parameter int MAX_WIDTH = bepe_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [bepe_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [bepe_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic      [$clog2(MAX_WIDTH):0]          width_eff,
  output logic      [bepe_pkg::CFG_HEIGHT_W-1:0]   height_eff,
  output logic      [bepe_pkg::COORD_W-1:0]        off_x,
  output logic      [bepe_pkg::COORD_W-1:0]        off_y
);
  import bepe_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH) + 1;
  localparam int CW = (CFG_WIDTH_W > WW) ? CFG_WIDTH_W : WW;

  logic [CFG_WIDTH_W-1:0]  raster_width;
  logic [CFG_HEIGHT_W-1:0] raster_height;
  logic [COORD_W-1:0]      offset_x;
  logic [COORD_W-1:0]      offset_y;
  logic [CW-1:0]           width_ext;
  logic [CW-1:0]           width_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      raster_width  <= RASTER_WIDTH_RESET;
      raster_height <= RASTER_HEIGHT_RESET;
      offset_x      <= '0;
      offset_y      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RASTER_WIDTH:  raster_width  <= cfg_data[CFG_WIDTH_W-1:0];
        REG_RASTER_HEIGHT: raster_height <= cfg_data[CFG_HEIGHT_W-1:0];
        REG_OFFSET_X:      offset_x      <= cfg_data[COORD_W-1:0];
        REG_OFFSET_Y:      offset_y      <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero size counts as one; a width above the line store saturates.
  always_comb begin
    width_ext = CW'(raster_width);
    if (width_ext == '0) begin
      width_sat = CW'(1);
    end else if (width_ext > CW'(MAX_WIDTH)) begin
      width_sat = CW'(MAX_WIDTH);
    end else begin
      width_sat = width_ext;
    end
  end

  assign width_eff  = WW'(width_sat);
  assign height_eff = (raster_height == '0) ? CFG_HEIGHT_W'(1) : raster_height;
  assign off_x      = offset_x;
  assign off_y      = offset_y;

endmodule

`default_nettype wire

@@ rtl/core/bepe_out.sv @@
// Output register of the result stream.
`default_nettype none

module bepe_out (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            load,
  input  wire bepe_pkg::result_t               res,
  input  wire logic                            m_tready,
  output logic                                 m_tvalid,
  output logic [bepe_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                 m_tuser,
  output logic                                 m_tlast
);
  import bepe_pkg::*;

  result_t held;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = {held.edge_y, held.edge_x};
  assign m_tuser = held.is_edge;
  assign m_tlast = held.glyph_done;

endmodule

`default_nettype wire

@@ rtl/core/bepe_checker.sv @@
// Port-level checks of the binary edge pixel extractor and their binding.
`default_nettype none

module bepe_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              s_tvalid,
  input wire logic                              s_tready,
  input wire logic                              m_tvalid,
  input wire logic                              m_tready,
  input wire logic [bepe_pkg::OUT_DATA_W-1:0]   m_tdata,
  input wire logic                              m_tuser,
  input wire logic                              m_tlast,
  input wire logic                              cfg_we
);
  import bepe_pkg::*;

  // A stalled result holds still.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result changed while stalled");

  // A full, stalled output register blocks the pixel stream.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("pixel taken while result stalled");

  // A result only follows a pixel transfer.
  a_result_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
    else $error("result without pixel transfer");

  // A configuration write starts the window reload.
  a_cfg_reload: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("pixel taken during window reload");

endmodule

bind binary_edge_pixel_extractor bepe_checker u_checker (.*);

`default_nettype wire
